// ===== sv/bvel_pkg.sv =====
// bvel_pkg: shared constants, types and helpers for the beacon vendor element locator
// no dependencies; used by beacon_vendor_element_locator
`timescale 1ns / 1ps
`default_nettype none

package bvel_pkg;

   // frame capacity in bytes
   localparam int MAX_FRAME_BYTES = 4096;
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   // element offsets may start past capacity (start register is 8 bits)
   localparam int OFF_W = (POS_W > 8) ? POS_W : 8;
   localparam int SUM_W = OFF_W + 1;

   // frame field positions
   localparam int DEST_FIRST = 4;
   localparam int DEST_LAST = 9;
   localparam int SRC_FIRST = 10;
   localparam int SRC_LAST = 15;
   localparam int PACK_DELTA = 7;
   localparam int LEN_DELTA = 6;
   localparam int OUI_DELTA_A = 5;
   localparam int OUI_DELTA_B = 4;
   localparam int OUI_DELTA_C = 3;

   localparam logic [7:0] TYPE_BEACON = 8'h80;
   localparam logic [7:0] TYPE_VENDOR = 8'hdd;
   localparam logic [7:0] MIN_START = 8'd24;
   localparam logic [7:0] MAX_COUNT = 8'hff;

   // register reset values
   localparam logic [47:0] DEST_ADDR_RESET = 48'h516f_9a01_0000;
   localparam logic [23:0] OUI_FIRST_RESET = 24'h903ae6;
   localparam logic [23:0] OUI_SECOND_RESET = 24'hfa0bbc;
   localparam logic [7:0] START_OFFSET_RESET = 8'd36;

   // register indexes (byte address / 8)
   localparam logic [1:0] REG_DEST_ADDR = 2'd0;
   localparam logic [1:0] REG_OUI_FIRST = 2'd1;
   localparam logic [1:0] REG_OUI_SECOND = 2'd2;
   localparam logic [1:0] REG_START_OFFSET = 2'd3;

   // result kinds
   localparam logic KIND_PACK = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // frame classes
   localparam logic [1:0] CLASS_IGNORED = 2'd0;
   localparam logic [1:0] CLASS_DISCOVERY = 2'd1;
   localparam logic [1:0] CLASS_BEACON = 2'd2;

   // result queue
   localparam int Q_DEPTH = 8;
   localparam int Q_AW = $clog2(Q_DEPTH);
   localparam int Q_CW = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic        kind;
      logic [11:0] pack_offset;
      logic [47:0] source_addr;
      logic [1:0]  frame_class;
      logic [12:0] frame_length;
      logic [7:0]  pack_count;
      logic        last;
   } result_type;

   function automatic logic [POS_W-1:0] clamp_pos(input logic [SUM_W-1:0] v);
      if (v > SUM_W'(MAX_FRAME_BYTES)) begin
         return POS_W'(MAX_FRAME_BYTES);
      end
      return v[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/beacon_vendor_element_locator.sv =====
// beacon_vendor_element_locator: byte-stream frame parser, vendor element finder and summary
// depends on bvel_pkg
//
//  channel   dir   beat                              handshake
//  req_*     in    one frame byte, last, mgmt flag   tvalid/tready
//  rsp_*     out   pack located or frame summary     tvalid/tready
//  csr_*     in    register write/read, 64-bit data  psel/penable, pready tied high
//
// one byte per cycle while req_tready is high; a byte is registered, parsed in the next cycle
// and its results land in an 8-entry result queue, whose head drives the rsp beats.
// a byte that ends the frame while a pack is located gives two beats; req_tready drops
// only while the queue may lack room for two beats.
// reset clears the queue and parser and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module beacon_vendor_element_locator (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [7:0] frame_byte
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   // req_tuser: [0] is_mgmt
   input  wire logic        req_tuser,
   // rsp_tdata: [11:0] pack_offset, [59:12] source_addr, [61:60] frame_class,
   //            [74:62] frame_length, [82:75] pack_count, [87:83] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tlast,
   // rsp_tuser: [0] result_kind
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int PW = bvel_pkg::POS_W;
   localparam int OW = bvel_pkg::OFF_W;
   localparam int SW = bvel_pkg::SUM_W;

   // configuration
   logic [47:0] dest_addr_ff;
   logic [23:0] oui_first_ff;
   logic [23:0] oui_second_ff;
   logic [7:0]  start_offset_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        in_mgmt_ff;

   // parser state
   logic [PW-1:0] pos_ff, pos_in;
   logic          mgmt_ff, mgmt_in;
   logic          beacon_ff, beacon_in;
   logic          dest_match_ff, dest_match_in;
   logic [OW-1:0] next_elem_ff, next_elem_in;
   logic [7:0]    elem_type_ff, elem_type_in;
   logic [23:0]   oui_ff, oui_in;
   logic [PW-1:0] pend_off_ff, pend_off_in;
   logic          pend_ff, pend_in;
   logic [47:0]   source_ff, source_in;
   logic [7:0]    total_ff, total_in;

   // result queue
   bvel_pkg::result_type q_ff [bvel_pkg::Q_DEPTH];
   logic [bvel_pkg::Q_AW-1:0] head_ff, tail_ff, tail_next;
   logic [bvel_pkg::Q_CW-1:0] count_ff, count_in;

   // parse intermediates
   logic          first;
   logic          mgmt_e, beacon_e, dest_e;
   logic [OW-1:0] next_e;
   logic [7:0]    etype_e;
   logic [23:0]   oui_e, oui_shifted;
   logic [PW-1:0] pend_off_e;
   logic          pend_e;
   logic [47:0]   source_e;
   logic [7:0]    total_e;
   logic [7:0]    start_eff;
   logic [7:0]    dest_byte;
   logic          below_cap;
   logic          walking;
   logic          hit;
   logic [SW-1:0] p_ext, pend_ext;
   logic [1:0]    frame_class;
   logic          push_pack, push_sum;
   bvel_pkg::result_type pack_entry, sum_entry, entry0, entry1;
   logic          pop;
   logic [bvel_pkg::Q_CW:0] room_need;
   bvel_pkg::result_type head_entry;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = csr_paddr[4:3];

   always_comb begin
      unique case (csr_index)
         bvel_pkg::REG_DEST_ADDR:    csr_prdata = {16'd0, dest_addr_ff};
         bvel_pkg::REG_OUI_FIRST:    csr_prdata = {40'd0, oui_first_ff};
         bvel_pkg::REG_OUI_SECOND:   csr_prdata = {40'd0, oui_second_ff};
         bvel_pkg::REG_START_OFFSET: csr_prdata = {56'd0, start_offset_ff};
         default:                    csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_addr_ff <= bvel_pkg::DEST_ADDR_RESET;
         oui_first_ff <= bvel_pkg::OUI_FIRST_RESET;
         oui_second_ff <= bvel_pkg::OUI_SECOND_RESET;
         start_offset_ff <= bvel_pkg::START_OFFSET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bvel_pkg::REG_DEST_ADDR:    dest_addr_ff <= csr_pwdata[47:0];
            bvel_pkg::REG_OUI_FIRST:    oui_first_ff <= csr_pwdata[23:0];
            bvel_pkg::REG_OUI_SECOND:   oui_second_ff <= csr_pwdata[23:0];
            bvel_pkg::REG_START_OFFSET: start_offset_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   assign room_need = (bvel_pkg::Q_CW + 1)'(count_ff)
                      + (in_valid_ff ? (bvel_pkg::Q_CW + 1)'(2) : (bvel_pkg::Q_CW + 1)'(0));
   assign req_tready = room_need <= (bvel_pkg::Q_CW + 1)'(bvel_pkg::Q_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_tvalid & req_tready;
      end
      if (req_tvalid & req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
         in_mgmt_ff <= req_tuser;
      end
   end

   // parser
   always_comb begin
      first = (pos_ff == '0);
      start_eff = (start_offset_ff < bvel_pkg::MIN_START) ? bvel_pkg::MIN_START
                                                          : start_offset_ff;
      mgmt_e = first ? in_mgmt_ff : mgmt_ff;
      beacon_e = first ? (in_byte_ff == bvel_pkg::TYPE_BEACON) : beacon_ff;
      dest_e = first ? 1'b1 : dest_match_ff;
      next_e = first ? OW'(start_eff) : next_elem_ff;
      etype_e = first ? 8'd0 : elem_type_ff;
      oui_e = first ? 24'd0 : oui_ff;
      pend_off_e = first ? '0 : pend_off_ff;
      pend_e = first ? 1'b0 : pend_ff;
      source_e = first ? 48'd0 : source_ff;
      total_e = first ? 8'd0 : total_ff;

      p_ext = SW'(pos_ff);
      pend_ext = SW'(pend_off_e);
      below_cap = pos_ff < PW'(bvel_pkg::MAX_FRAME_BYTES);

      // destination byte for this position, first byte most significant
      case (pos_ff)
         PW'(4):  dest_byte = dest_addr_ff[47:40];
         PW'(5):  dest_byte = dest_addr_ff[39:32];
         PW'(6):  dest_byte = dest_addr_ff[31:24];
         PW'(7):  dest_byte = dest_addr_ff[23:16];
         PW'(8):  dest_byte = dest_addr_ff[15:8];
         PW'(9):  dest_byte = dest_addr_ff[7:0];
         default: dest_byte = 8'd0;
      endcase

      dest_match_in = dest_e;
      source_in = source_e;
      mgmt_in = mgmt_e;
      beacon_in = beacon_e;
      next_elem_in = next_e;
      elem_type_in = etype_e;
      oui_in = oui_e;
      pend_off_in = pend_off_e;
      pend_in = pend_e;
      total_in = total_e;
      hit = 1'b0;
      oui_shifted = {oui_e[15:0], in_byte_ff};

      if (below_cap) begin
         if (pos_ff >= PW'(bvel_pkg::DEST_FIRST) && pos_ff <= PW'(bvel_pkg::DEST_LAST)) begin
            if (dest_byte != in_byte_ff) begin
               dest_match_in = 1'b0;
            end
         end else if (pos_ff >= PW'(bvel_pkg::SRC_FIRST)
                      && pos_ff <= PW'(bvel_pkg::SRC_LAST)) begin
            source_in = {source_e[39:0], in_byte_ff};
         end
      end

      walking = below_cap && mgmt_e && beacon_e && !dest_e
                && pos_ff >= PW'(bvel_pkg::SRC_FIRST);

      if (walking) begin
         if (pend_e && pos_ff == pend_off_e) begin
            hit = 1'b1;
            if (total_e < bvel_pkg::MAX_COUNT) begin
               total_in = total_e + 8'd1;
            end
            pend_in = 1'b0;
         end
         if (p_ext == SW'(next_e)) begin
            elem_type_in = in_byte_ff;
            pend_off_in = bvel_pkg::clamp_pos(p_ext + SW'(bvel_pkg::PACK_DELTA));
            oui_in = 24'd0;
            pend_in = 1'b0;
         end else if (p_ext + SW'(bvel_pkg::LEN_DELTA) == pend_ext) begin
            next_elem_in = OW'(bvel_pkg::clamp_pos(p_ext + SW'(1) + SW'(in_byte_ff)));
         end else if (p_ext + SW'(bvel_pkg::OUI_DELTA_A) == pend_ext
                      || p_ext + SW'(bvel_pkg::OUI_DELTA_B) == pend_ext) begin
            oui_in = oui_shifted;
         end else if (p_ext + SW'(bvel_pkg::OUI_DELTA_C) == pend_ext) begin
            oui_in = oui_shifted;
            if (etype_e == bvel_pkg::TYPE_VENDOR && SW'(next_e) >= pend_ext
                && (oui_shifted == oui_first_ff || oui_shifted == oui_second_ff)) begin
               pend_in = 1'b1;
            end
         end
      end

      pos_in = bvel_pkg::clamp_pos(p_ext + SW'(1));

      frame_class = bvel_pkg::CLASS_IGNORED;
      if (mgmt_e) begin
         if (dest_match_in && pos_in >= PW'(bvel_pkg::SRC_FIRST)) begin
            frame_class = bvel_pkg::CLASS_DISCOVERY;
         end else if (beacon_e) begin
            frame_class = bvel_pkg::CLASS_BEACON;
         end
      end

      push_pack = in_valid_ff & hit;
      push_sum = in_valid_ff & in_last_ff;

      pack_entry.kind = bvel_pkg::KIND_PACK;
      pack_entry.pack_offset = 12'(pend_off_e);
      pack_entry.source_addr = source_in;
      pack_entry.frame_class = bvel_pkg::CLASS_BEACON;
      pack_entry.frame_length = 13'd0;
      pack_entry.pack_count = 8'd0;
      pack_entry.last = ~in_last_ff;

      sum_entry.kind = bvel_pkg::KIND_SUMMARY;
      sum_entry.pack_offset = 12'd0;
      sum_entry.source_addr = source_in;
      sum_entry.frame_class = frame_class;
      sum_entry.frame_length = 13'(pos_in);
      sum_entry.pack_count = total_in;
      sum_entry.last = 1'b1;

      entry0 = push_pack ? pack_entry : sum_entry;
      entry1 = sum_entry;

      if (in_last_ff) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         mgmt_ff <= 1'b0;
         beacon_ff <= 1'b0;
         dest_match_ff <= 1'b1;
         next_elem_ff <= '0;
         elem_type_ff <= 8'd0;
         oui_ff <= 24'd0;
         pend_off_ff <= '0;
         pend_ff <= 1'b0;
         source_ff <= 48'd0;
         total_ff <= 8'd0;
      end else if (in_valid_ff) begin
         pos_ff <= pos_in;
         mgmt_ff <= mgmt_in;
         beacon_ff <= beacon_in;
         dest_match_ff <= dest_match_in;
         next_elem_ff <= next_elem_in;
         elem_type_ff <= elem_type_in;
         oui_ff <= oui_in;
         pend_off_ff <= pend_off_in;
         pend_ff <= pend_in;
         source_ff <= source_in;
         total_ff <= total_in;
      end
   end

   // result queue
   assign pop = rsp_tvalid & rsp_tready;
   assign tail_next = bvel_pkg::Q_AW'(tail_ff + 1'b1);

   always_comb begin
      count_in = count_ff;
      if (push_pack) begin
         count_in = count_in + 1'b1;
      end
      if (push_sum) begin
         count_in = count_in + 1'b1;
      end
      if (pop) begin
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            head_ff <= bvel_pkg::Q_AW'(head_ff + 1'b1);
         end
         if (push_pack && push_sum) begin
            tail_ff <= bvel_pkg::Q_AW'(tail_ff + 2'd2);
         end else if (push_pack || push_sum) begin
            tail_ff <= tail_next;
         end
      end
      if (push_pack || push_sum) begin
         q_ff[tail_ff] <= entry0;
      end
      if (push_pack && push_sum) begin
         q_ff[tail_next] <= entry1;
      end
   end

   assign head_entry = q_ff[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser = head_entry.kind;
   assign rsp_tlast = head_entry.last;
   assign rsp_tdata = {5'd0, head_entry.pack_count, head_entry.frame_length,
                       head_entry.frame_class, head_entry.source_addr,
                       head_entry.pack_offset};

endmodule

`default_nettype wire
